[rtl/sbsd_pkg.sv]
// ----------------------------------------------------------------------------
// sbsd_pkg
// Shared constants, widths and types of the sensor baseline settle detector.
// ----------------------------------------------------------------------------
package sbsd_pkg;

  // averaging window length in samples
  localparam int unsigned WINDOW   = 10;
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned POS_W    = $clog2(WINDOW);
  // running sum holds WINDOW * full scale without wrapping
  localparam int unsigned SUM_W    = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);

  // reciprocal for the divide by WINDOW, exact over the whole sum range
  localparam int unsigned SHIFT    = SUM_W + $clog2(WINDOW);
  localparam int unsigned RECIP_W  = SUM_W + 1;
  localparam int unsigned PROD_W   = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  // history row holds the three channel samples side by side
  localparam int unsigned ROW_W    = 3 * SAMPLE_W;

  // reset value of the settle delta register
  localparam logic [SAMPLE_W-1:0] DELTA_RESET = SAMPLE_W'(2);

  // stage moves shared by the channel lanes
  typedef struct packed {
    logic s1_fire;
    logic s2_fire;
  } sbsd_ctrl_t;

endpackage

[rtl/sbsd_if.sv]
// ----------------------------------------------------------------------------
// sbsd_if
// Valid/ready channels of the detector: sample items, result items and the
// settle delta write channel.
// ----------------------------------------------------------------------------
interface sbsd_in_if import sbsd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_co;
  logic [SAMPLE_W-1:0] sample_nh3;
  logic [SAMPLE_W-1:0] sample_no2;

  modport source (output valid, output sample_co, output sample_nh3,
                  output sample_no2, input ready);
  modport sink   (input valid, input sample_co, input sample_nh3,
                  input sample_no2, output ready);
endinterface

interface sbsd_out_if import sbsd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                stable_co;
  logic                stable_nh3;
  logic                stable_no2;
  logic                all_stable;
  logic [SAMPLE_W-1:0] average_co;
  logic [SAMPLE_W-1:0] average_nh3;
  logic [SAMPLE_W-1:0] average_no2;

  modport source (output valid, output stable_co, output stable_nh3,
                  output stable_no2, output all_stable, output average_co,
                  output average_nh3, output average_no2, input ready);
  modport sink   (input valid, input stable_co, input stable_nh3,
                  input stable_no2, input all_stable, input average_co,
                  input average_nh3, input average_no2, output ready);
endinterface

interface sbsd_cfg_if import sbsd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] settle_delta;

  modport source (output valid, output settle_delta, input ready);
  modport sink   (input valid, input settle_delta, output ready);
endinterface

[rtl/sbsd_ram.sv]
// ----------------------------------------------------------------------------
// sbsd_ram
// Generic single-clock RAM: one write port, one read port with registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module sbsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/sbsd_chan.sv]
// ----------------------------------------------------------------------------
// sbsd_chan
// One channel lane: running window sum, divide by the window length through
// a reciprocal multiply, and the settle compare against the delta.
// ----------------------------------------------------------------------------
module sbsd_chan import sbsd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sbsd_ctrl_t          ctrl_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic [SAMPLE_W-1:0] oldest_i,
  input  logic [SAMPLE_W-1:0] delta_i,
  output logic [SAMPLE_W-1:0] average_o,
  output logic                stable_o
);

  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [SUM_W-1:0]    s2_sum_q;
  logic [SAMPLE_W-1:0] s2_smp_q;
  logic [PROD_W-1:0]   prod;
  logic [SAMPLE_W-1:0] avg_d;
  logic [SAMPLE_W-1:0] avg_q;
  logic [SAMPLE_W-1:0] smp_q;
  logic [SAMPLE_W-1:0] diff;

  // new sample in, oldest entry out
  assign sum_d = sum_q + SUM_W'(sample_i) - SUM_W'(oldest_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctrl_i.s1_fire) begin
      sum_q <= sum_d;
    end
  end

  // stage 2 operands
  always_ff @(posedge clk_i) begin
    if (ctrl_i.s1_fire) begin
      s2_sum_q <= sum_d;
      s2_smp_q <= sample_i;
    end
  end

  // truncating divide by the window length
  assign prod  = PROD_W'(s2_sum_q) * PROD_W'(RECIP);
  assign avg_d = SAMPLE_W'(prod >> SHIFT);

  // output register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.s2_fire) begin
      avg_q <= avg_d;
      smp_q <= s2_smp_q;
    end
  end

  // absolute difference against the delta
  assign diff      = (avg_q >= smp_q) ? (avg_q - smp_q) : (smp_q - avg_q);
  assign stable_o  = (diff < delta_i);
  assign average_o = avg_q;

endmodule

[rtl/sensor_baseline_settle_detector_top.sv]
// ----------------------------------------------------------------------------
// sensor_baseline_settle_detector_top
// Moving-average settle detector over three gas sensor channels.
// ----------------------------------------------------------------------------
// The block takes one item of three samples per clock cycle unless the result
// side stalls it, and returns one result item per input item. The sample
// history of all three channels sits in one RAM row per window slot: an item
// reads its slot when it is accepted, stage 1 then updates the running sums
// and writes the new samples back, stage 2 does the reciprocal multiply for
// the divide, and the result is then held in the output register. Unwritten
// slots read as zero through per-slot valid bits that reset clears at once,
// so no clearing pass is needed. The settle delta resets to 2 and is written
// through the configuration channel, which is always ready.
// ----------------------------------------------------------------------------
module sensor_baseline_settle_detector_top import sbsd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  sbsd_in_if.sink   sample_i,
  sbsd_out_if.source result_o,
  sbsd_cfg_if.sink  cfg_i
);

  logic [SAMPLE_W-1:0] delta_q;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [WINDOW-1:0]   valid_q;
  logic                s1_vld_q, s2_vld_q, out_vld_q;
  logic [POS_W-1:0]    s1_pos_q;
  logic                rd_valid_q;
  logic [SAMPLE_W-1:0] s1_co_q, s1_nh3_q, s1_no2_q;
  logic                in_fire;
  sbsd_ctrl_t          ctrl;
  logic [ROW_W-1:0]    rdata;
  logic [ROW_W-1:0]    oldest;
  logic [ROW_W-1:0]    wdata;

  // configuration register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_q <= DELTA_RESET;
    end else if (cfg_i.valid) begin
      delta_q <= cfg_i.settle_delta;
    end
  end

  // pipeline handshake
  assign ctrl.s2_fire   = s2_vld_q && (!out_vld_q || result_o.ready);
  assign ctrl.s1_fire   = s1_vld_q && (!s2_vld_q || ctrl.s2_fire);
  assign sample_i.ready = !s1_vld_q || ctrl.s1_fire;
  assign in_fire        = sample_i.valid && sample_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_vld_q <= 1'b1;
      end else if (ctrl.s1_fire) begin
        s1_vld_q <= 1'b0;
      end
      if (ctrl.s1_fire) begin
        s2_vld_q <= 1'b1;
      end else if (ctrl.s2_fire) begin
        s2_vld_q <= 1'b0;
      end
      if (ctrl.s2_fire) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // ring write position
  assign pos_d = (pos_q == POS_W'(WINDOW - 1)) ? '0 : pos_q + POS_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (in_fire) begin
      pos_q <= pos_d;
    end
  end

  // per-slot written flags, so untouched slots read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctrl.s1_fire) begin
      valid_q[s1_pos_q] <= 1'b1;
    end
  end

  // stage 1 item capture alongside the RAM read
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pos_q   <= pos_q;
      rd_valid_q <= valid_q[pos_q];
      s1_co_q    <= sample_i.sample_co;
      s1_nh3_q   <= sample_i.sample_nh3;
      s1_no2_q   <= sample_i.sample_no2;
    end
  end

  // history memory: read at accept, write back when stage 1 moves on
  assign wdata = {s1_co_q, s1_nh3_q, s1_no2_q};

  sbsd_ram #(
    .WIDTH (ROW_W),
    .DEPTH (WINDOW)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ctrl.s1_fire),
    .waddr_i (s1_pos_q),
    .wdata_i (wdata),
    .re_i    (in_fire),
    .raddr_i (pos_q),
    .rdata_o (rdata)
  );

  assign oldest = rd_valid_q ? rdata : '0;

  // channel lanes
  sbsd_chan u_co (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .sample_i  (s1_co_q),
    .oldest_i  (oldest[3*SAMPLE_W-1:2*SAMPLE_W]),
    .delta_i   (delta_q),
    .average_o (result_o.average_co),
    .stable_o  (result_o.stable_co)
  );

  sbsd_chan u_nh3 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .sample_i  (s1_nh3_q),
    .oldest_i  (oldest[2*SAMPLE_W-1:SAMPLE_W]),
    .delta_i   (delta_q),
    .average_o (result_o.average_nh3),
    .stable_o  (result_o.stable_nh3)
  );

  sbsd_chan u_no2 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .sample_i  (s1_no2_q),
    .oldest_i  (oldest[SAMPLE_W-1:0]),
    .delta_i   (delta_q),
    .average_o (result_o.average_no2),
    .stable_o  (result_o.stable_no2)
  );

  // result item
  assign result_o.valid      = out_vld_q;
  assign result_o.all_stable = result_o.stable_co && result_o.stable_nh3 &&
                               result_o.stable_no2;

  // read and write-back never target the same slot in one cycle
  a_no_slot_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && ctrl.s1_fire) |-> (pos_q != s1_pos_q))
    else $error("history read and write hit the same slot");

  // write position stays inside the window
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(WINDOW - 1))
    else $error("write position outside the window");

  // a written slot is marked valid afterwards
  a_slot_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.s1_fire |=> valid_q[$past(s1_pos_q)])
    else $error("written slot not marked valid");

  // a result only appears after the multiply stage held an item
  a_out_from_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(s2_vld_q))
    else $error("result valid without a stage 2 item");

  // an item in stage 1 is not dropped while stalled
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && !ctrl.s1_fire) |=> (s1_vld_q && $stable(s1_pos_q)))
    else $error("stalled stage 1 item lost");

endmodule

[bench/sbsd_baseline_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sbsd_baseline_checker
// Watches the sample, result and settle delta channels of the detector. It
// keeps its own copy of the three sample windows, running sums and delta, and
// works out the result of every accepted sample item. Each accepted result
// item is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module sbsd_baseline_checker import sbsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  sbsd_in_if          samples_i,
  sbsd_out_if         results_i,
  sbsd_cfg_if         cfg_i,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);

  localparam int unsigned NUM_CH = 3;
  localparam int unsigned CH_CO  = 0;
  localparam int unsigned CH_NH3 = 1;
  localparam int unsigned CH_NO2 = 2;

  typedef struct packed {
    logic                stable_co;
    logic                stable_nh3;
    logic                stable_no2;
    logic                all_stable;
    logic [SAMPLE_W-1:0] average_co;
    logic [SAMPLE_W-1:0] average_nh3;
    logic [SAMPLE_W-1:0] average_no2;
  } baseline_result_t;

  // window state of the three channels
  logic [SAMPLE_W-1:0] history_q [NUM_CH][WINDOW];
  logic [SUM_W-1:0]    sum_q [NUM_CH];
  int unsigned         slot_q;
  logic [SAMPLE_W-1:0] delta_q;

  baseline_result_t    baseline_q [$];
  baseline_result_t    oldest;
  int unsigned         result_idx;

  // one line per mismatch, and count it
  task automatic report_mismatch(input string what);
    $display("%0t ns settle check: result %0d: %s", $time, result_idx, what);
    fail_count_o++;
  endtask

  task automatic check_field(input string field, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", field, got, want));
    end
  endtask

  // slide the windows by one tick and derive the flags and averages
  function automatic baseline_result_t next_baseline(input logic [SAMPLE_W-1:0] co,
                                                     input logic [SAMPLE_W-1:0] nh3,
                                                     input logic [SAMPLE_W-1:0] no2);
    logic [SAMPLE_W-1:0] smp [NUM_CH];
    logic [SAMPLE_W-1:0] avg [NUM_CH];
    logic                flag [NUM_CH];
    logic [SAMPLE_W-1:0] gap;
    baseline_result_t    r;
    smp[CH_CO]  = co;
    smp[CH_NH3] = nh3;
    smp[CH_NO2] = no2;
    for (int c = 0; c < NUM_CH; c++) begin
      // oldest entry leaves the sum, new sample takes its slot
      sum_q[c] = sum_q[c] + SUM_W'(smp[c]) - SUM_W'(history_q[c][slot_q]);
      history_q[c][slot_q] = smp[c];
      avg[c]  = SAMPLE_W'(sum_q[c] / SUM_W'(WINDOW));
      gap     = (avg[c] >= smp[c]) ? avg[c] - smp[c] : smp[c] - avg[c];
      flag[c] = gap < delta_q;
    end
    slot_q = (slot_q == WINDOW - 1) ? 0 : slot_q + 1;
    r.stable_co   = flag[CH_CO];
    r.stable_nh3  = flag[CH_NH3];
    r.stable_no2  = flag[CH_NO2];
    r.all_stable  = flag[CH_CO] & flag[CH_NH3] & flag[CH_NO2];
    r.average_co  = avg[CH_CO];
    r.average_nh3 = avg[CH_NH3];
    r.average_no2 = avg[CH_NO2];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CH; c++) begin
        for (int s = 0; s < WINDOW; s++) history_q[c][s] = '0;
        sum_q[c] = '0;
      end
      slot_q       = 0;
      delta_q      = DELTA_RESET;
      result_idx   = 0;
      fail_count_o = 0;
      baseline_q.delete();
      pending_o   <= 0;
    end else begin
      // settle delta write
      if (cfg_i.valid && cfg_i.ready) begin
        delta_q = cfg_i.settle_delta;
      end
      // result item against the oldest expectation
      if (results_i.valid && results_i.ready) begin
        if (baseline_q.size() == 0) begin
          report_mismatch("result item with nothing expected");
        end else begin
          oldest = baseline_q.pop_front();
          check_field("stable_co", results_i.stable_co, oldest.stable_co);
          check_field("stable_nh3", results_i.stable_nh3, oldest.stable_nh3);
          check_field("stable_no2", results_i.stable_no2, oldest.stable_no2);
          check_field("all_stable", results_i.all_stable, oldest.all_stable);
          check_field("average_co", results_i.average_co, oldest.average_co);
          check_field("average_nh3", results_i.average_nh3, oldest.average_nh3);
          check_field("average_no2", results_i.average_no2, oldest.average_no2);
        end
        result_idx++;
      end
      // sample item: predict its result
      if (samples_i.valid && samples_i.ready) begin
        baseline_q.push_back(next_baseline(samples_i.sample_co, samples_i.sample_nh3,
                                           samples_i.sample_no2));
      end
      pending_o <= baseline_q.size();
    end
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Regression of the sensor baseline settle detector. Drives sample items and
// settle delta writes, stalls the result side at random, and takes the
// verdict from the checker that sits beside the block.
// ----------------------------------------------------------------------------
module tb_top import sbsd_pkg::*; ();

  localparam int unsigned CLK_PERIOD   = 4;
  localparam int unsigned RESET_CYCLES = 8;
  localparam int unsigned LIMIT_CYCLES = 100_000;
  localparam int unsigned TAIL_CYCLES  = 8;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned IDLE_PCT     = 10;
  localparam int unsigned MAX_SAMPLE   = (1 << SAMPLE_W) - 1;

  logic        clk_i;
  logic        rst_ni;

  sbsd_in_if   sample_if ();
  sbsd_out_if  result_if ();
  sbsd_cfg_if  cfg_if ();

  int unsigned pending_results;
  int unsigned fail_count;

  // stimulus and stall control
  logic                src_idle_en;
  logic                sink_idle_en;
  int unsigned         hold_requests;
  int unsigned         holds_served;
  int unsigned         hold_left;
  int unsigned         items_sent;
  logic [SAMPLE_W-1:0] delta_now;

  sensor_baseline_settle_detector_top i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  sbsd_baseline_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .samples_i    (sample_if),
    .results_i    (result_if),
    .cfg_i        (cfg_if),
    .pending_o    (pending_results),
    .fail_count_o (fail_count)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("sensor_baseline_settle_detector_top regression: fail");
    $finish;
  end

  // result side: random stalls, requested hold-offs
  initial begin
    result_if.ready = 1'b0;
    holds_served    = 0;
    hold_left       = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        result_if.ready <= 1'b0;
        hold_left--;
      end else if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES - 1;
        result_if.ready <= 1'b0;
      end else if (!sink_idle_en) begin
        result_if.ready <= 1'b1;
      end else begin
        result_if.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // offer one sample item, with an occasional gap before it
  task automatic offer_samples(input logic [SAMPLE_W-1:0] co,
                               input logic [SAMPLE_W-1:0] nh3,
                               input logic [SAMPLE_W-1:0] no2);
    if (src_idle_en && $urandom_range(99) < IDLE_PCT) begin
      sample_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_if.valid      <= 1'b1;
    sample_if.sample_co  <= co;
    sample_if.sample_nh3 <= nh3;
    sample_if.sample_no2 <= no2;
    @(posedge clk_i);
    while (!sample_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  // stop offering and let every outstanding result come back
  task automatic wait_all_results();
    sample_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
  endtask

  task automatic write_delta(input logic [SAMPLE_W-1:0] value);
    cfg_if.valid        <= 1'b1;
    cfg_if.settle_delta <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    delta_now = value;
  endtask

  // a steady level per channel with noise scaled to the delta
  task automatic settle_run();
    int                  base [3];
    int                  spread;
    int                  v;
    logic [SAMPLE_W-1:0] smp [3];
    for (int c = 0; c < 3; c++) begin
      case ($urandom_range(9))
        0:       base[c] = 0;
        1:       base[c] = MAX_SAMPLE;
        default: base[c] = $urandom_range(0, MAX_SAMPLE);
      endcase
    end
    case ($urandom_range(3))
      0:       spread = 0;
      1:       spread = delta_now / 2;
      2:       spread = delta_now;
      default: spread = 4 * delta_now + 8;
    endcase
    if (spread > MAX_SAMPLE) spread = MAX_SAMPLE;
    repeat ($urandom_range(10, 30)) begin
      for (int c = 0; c < 3; c++) begin
        v = base[c] + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > MAX_SAMPLE) v = MAX_SAMPLE;
        smp[c] = SAMPLE_W'(v);
      end
      offer_samples(smp[0], smp[1], smp[2]);
    end
  endtask

  // mostly settling runs, the rest full-range noise
  task automatic run_phase(input int unsigned count);
    int unsigned stop;
    stop = items_sent + count;
    while (items_sent < stop) begin
      if ($urandom_range(99) < 75) begin
        settle_run();
      end else begin
        repeat ($urandom_range(1, 8)) begin
          offer_samples(SAMPLE_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom));
        end
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    rst_ni               = 1'b0;
    sample_if.valid      = 1'b0;
    sample_if.sample_co  = '0;
    sample_if.sample_nh3 = '0;
    sample_if.sample_no2 = '0;
    cfg_if.valid         = 1'b0;
    cfg_if.settle_delta  = '0;
    src_idle_en          = 1'b1;
    sink_idle_en         = 1'b1;
    hold_requests        = 0;
    items_sent           = 0;
    delta_now            = DELTA_RESET;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // warm-up from the cleared windows under the reset delta
    offer_samples('0, '0, '0);
    repeat (10) offer_samples(SAMPLE_W'(MAX_SAMPLE), SAMPLE_W'(MAX_SAMPLE),
                              SAMPLE_W'(MAX_SAMPLE));
    offer_samples(SAMPLE_W'(MAX_SAMPLE), '0, SAMPLE_W'(MAX_SAMPLE));
    offer_samples(12'hAAA, 12'h555, 12'hAAA);
    offer_samples(12'h555, 12'hAAA, 12'h555);
    offer_samples('0, SAMPLE_W'(MAX_SAMPLE), '0);
    offer_samples(12'd1, 12'd2, 12'd4094);
    // settling on a constant level, then kept running once all stable
    repeat (12) offer_samples(12'd2047, 12'd2047, 12'd2047);

    // zero delta: nothing can be stable
    wait_all_results();
    write_delta('0);
    run_phase(100);

    // tightest delta, with a long hold-off on the result side
    wait_all_results();
    write_delta(12'd1);
    hold_requests <= hold_requests + 1;
    run_phase(130);

    // widest delta
    wait_all_results();
    write_delta(SAMPLE_W'(MAX_SAMPLE));
    run_phase(120);

    // stretch with no idling on either side
    wait_all_results();
    write_delta(SAMPLE_W'($urandom_range(1, 64)));
    src_idle_en  = 1'b0;
    sink_idle_en <= 1'b0;
    run_phase(200);
    src_idle_en  = 1'b1;
    sink_idle_en <= 1'b1;

    // random deltas, small and full range in turn
    for (int p = 0; p < 5; p++) begin
      wait_all_results();
      if (p % 2 == 0) begin
        write_delta(SAMPLE_W'($urandom_range(1, 64)));
      end else begin
        write_delta(SAMPLE_W'($urandom_range(1, MAX_SAMPLE)));
      end
      if (p == 3) hold_requests <= hold_requests + 1;
      run_phase(120);
    end

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0) begin
      $display("sensor_baseline_settle_detector_top regression: pass");
    end else begin
      $display("sensor_baseline_settle_detector_top regression: fail");
    end
    $finish;
  end

endmodule
